/* design/ffba_pkg.sv */
`default_nettype none

package ffba_pkg;

   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 6;

   // item opcodes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // result status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_IGNORED  = 2'd1;
   localparam logic [1:0] ST_NO_ROOM  = 2'd2;
   localparam logic [1:0] ST_NO_BLOCK = 2'd3;

   typedef struct packed {
      logic [31:0] header;
      logic [31:0] size;
      logic        used;
   } entry_type;

   // configuration seen by the sequencer
   typedef struct packed {
      logic        clear;   // region_start written this cycle
      logic [31:0] start;   // value being written to region_start
      logic [31:0] bytes;   // current region_bytes
   } cfg_type;

endpackage

`default_nettype wire

/* design/ffba_table.sv */
`default_nettype none

module ffba_table #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(MAX_BLOCKS)-1:0] wr_addr,
   input  wire ffba_pkg::entry_type           wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
   output ffba_pkg::entry_type                rd_data
);
   import ffba_pkg::*;

   entry_type mem_ff [MAX_BLOCKS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/ffba_ctrl.sv */
`default_nettype none

module ffba_ctrl #(
   parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ffba_pkg::cfg_type             cfg,
   // item in
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_op,
   input  wire logic [31:0]                   req_request_bytes,
   input  wire logic [31:0]                   req_payload_address,
   input  wire logic [5:0]                    req_block_index,
   // item out
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [31:0]                        rsp_result_payload,
   output logic [31:0]                        rsp_result_header,
   output logic [31:0]                        rsp_result_size,
   output logic                               rsp_result_in_use,
   output logic [31:0]                        rsp_region_end,
   output logic [31:0]                        rsp_bytes_in_use,
   output logic [31:0]                        rsp_bytes_reserved,
   // table port
   output logic                               mem_wr_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]      mem_wr_addr,
   output ffba_pkg::entry_type                mem_wr_data,
   output logic                               mem_rd_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]      mem_rd_addr,
   input  wire ffba_pkg::entry_type           mem_rd_data
);
   import ffba_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_QRD    = 3'd2;
   localparam logic [2:0] S_QWT    = 3'd3;
   localparam logic [2:0] S_APPEND = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;

   localparam logic [2:0] K_REUSE  = 3'd0;
   localparam logic [2:0] K_APPEND = 3'd1;
   localparam logic [2:0] K_FREE   = 3'd2;
   localparam logic [2:0] K_QUERY  = 3'd3;
   localparam logic [2:0] K_FAIL   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   req_bytes_ff, req_bytes_in;
   logic [31:0]   target_ff, target_in;
   logic [5:0]    idx_ff, idx_in;
   logic [32:0]   need_ff, need_in;
   logic [CW-1:0] scan_ptr_ff, scan_ptr_in;
   logic          chk_valid_ff, chk_valid_in;
   logic          chk_last_ff, chk_last_in;
   logic [CW-1:0] chk_idx_ff, chk_idx_in;
   logic [2:0]    kind_ff, kind_in;
   logic [1:0]    fail_status_ff, fail_status_in;
   entry_type     hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   bump_ff, bump_in;
   logic [31:0]   reserved_ff, reserved_in;
   logic [31:0]   used_total_ff, used_total_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_payload_ff, rsp_payload_in;
   logic [31:0]   rsp_header_ff, rsp_header_in;
   logic [31:0]   rsp_size_ff, rsp_size_in;
   logic          rsp_in_use_ff, rsp_in_use_in;
   logic [31:0]   rsp_end_ff, rsp_end_in;
   logic [31:0]   rsp_used_ff, rsp_used_in;
   logic [31:0]   rsp_reserved_ff, rsp_reserved_in;

   logic          accept;
   logic          out_free;
   logic          commit;
   logic          issue;
   logic [CW-1:0] ptr_next;
   logic          alloc_fit;
   logic          free_match;
   logic          hit;
   logic [31:0]   idx_wide;
   logic          query_ok;
   logic [33:0]   sum_reserved;
   logic [33:0]   sum_end;
   logic          append_fail;
   logic          done;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == S_COMMIT) && out_free;
   assign issue    = scan_ptr_ff < count_ff;
   assign ptr_next = scan_ptr_ff + CW'(1);
   assign idx_wide = 32'(idx_ff);
   assign query_ok = 32'(req_block_index) < 32'(count_ff);

   assign alloc_fit  = !mem_rd_data.used && (mem_rd_data.size >= req_bytes_ff);
   assign free_match = mem_rd_data.header == target_ff;
   assign hit        = chk_valid_ff && ((op_ff == OP_ALLOC) ? alloc_fit : free_match);

   assign sum_reserved = 34'(reserved_ff) + 34'(need_ff);
   assign sum_end      = 34'(bump_ff) + 34'(need_ff);
   assign append_fail  = (count_ff == CW'(MAX_BLOCKS)) ||
                         (sum_reserved > 34'(cfg.bytes)) ||
                         (sum_end[33:32] != 2'b00);

   assign done = kind_ff != K_FAIL;

   // Table writes happen only in S_COMMIT and reads only in the other states,
   // so a read never overlaps a pending write to the same entry.
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = scan_ptr_ff[IW-1:0];
      if (state_ff == S_SCAN) begin
         mem_rd_en = issue;
      end else if (state_ff == S_QRD) begin
         mem_rd_en   = 1'b1;
         mem_rd_addr = idx_wide[IW-1:0];
      end
      mem_wr_en          = commit && (kind_ff == K_REUSE || kind_ff == K_APPEND ||
                                      kind_ff == K_FREE);
      mem_wr_addr        = hit_idx_ff;
      mem_wr_data        = hit_ff;
      mem_wr_data.used   = kind_ff != K_FREE;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      req_bytes_in   = req_bytes_ff;
      target_in      = target_ff;
      idx_in         = idx_ff;
      need_in        = need_ff;
      scan_ptr_in    = scan_ptr_ff;
      chk_valid_in   = 1'b0;
      chk_last_in    = ptr_next == count_ff;
      chk_idx_in     = scan_ptr_ff;
      kind_in        = kind_ff;
      fail_status_in = fail_status_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      count_in       = count_ff;
      bump_in        = bump_ff;
      reserved_in    = reserved_ff;
      used_total_in  = used_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      rsp_status_in   = rsp_status_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_header_in   = rsp_header_ff;
      rsp_size_in     = rsp_size_ff;
      rsp_in_use_in   = rsp_in_use_ff;
      rsp_end_in      = rsp_end_ff;
      rsp_used_in     = rsp_used_ff;
      rsp_reserved_in = rsp_reserved_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in          = req_op;
               req_bytes_in   = req_request_bytes;
               target_in      = req_payload_address - 32'(HEADER_BYTES);
               idx_in         = req_block_index;
               need_in        = 33'(req_request_bytes) + 33'(HEADER_BYTES);
               scan_ptr_in    = '0;
               kind_in        = K_FAIL;
               fail_status_in = ST_IGNORED;
               state_in       = S_COMMIT;
               case (req_op)
                  OP_ALLOC: begin
                     if (req_request_bytes != '0) begin
                        state_in = (count_ff == '0) ? S_APPEND : S_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (req_payload_address != '0 && count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_QUERY: begin
                     if (query_ok) begin
                        state_in = S_QRD;
                     end else begin
                        fail_status_in = ST_NO_BLOCK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               hit_in     = mem_rd_data;
               hit_idx_in = chk_idx_ff[IW-1:0];
               if (op_ff == OP_ALLOC) begin
                  kind_in = K_REUSE;
               end else if (mem_rd_data.used) begin
                  kind_in = K_FREE;
               end else begin
                  kind_in        = K_FAIL;
                  fail_status_in = ST_IGNORED;
               end
               state_in = S_COMMIT;
            end else if (chk_valid_ff && chk_last_ff) begin
               if (op_ff == OP_ALLOC) begin
                  state_in = S_APPEND;
               end else begin
                  kind_in        = K_FAIL;
                  fail_status_in = ST_IGNORED;
                  state_in       = S_COMMIT;
               end
            end else if (issue) begin
               chk_valid_in = 1'b1;
               scan_ptr_in  = ptr_next;
            end
         end
         S_QRD: begin
            state_in = S_QWT;
         end
         S_QWT: begin
            hit_in   = mem_rd_data;
            kind_in  = K_QUERY;
            state_in = S_COMMIT;
         end
         S_APPEND: begin
            if (append_fail) begin
               kind_in        = K_FAIL;
               fail_status_in = ST_NO_ROOM;
            end else begin
               kind_in     = K_APPEND;
               hit_in      = '{header: bump_ff, size: req_bytes_ff, used: 1'b1};
               hit_idx_in  = count_ff[IW-1:0];
            end
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               case (kind_ff)
                  K_REUSE:  used_total_in = used_total_ff + hit_ff.size;
                  K_FREE:   used_total_in = used_total_ff - hit_ff.size;
                  K_APPEND: begin
                     used_total_in = used_total_ff + hit_ff.size;
                     count_in      = count_ff + CW'(1);
                     bump_in       = bump_ff + need_ff[31:0];
                     reserved_in   = reserved_ff + need_ff[31:0];
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in    = 1'b1;
               rsp_status_in   = done ? ST_DONE : fail_status_ff;
               rsp_payload_in  = done ? hit_ff.header + 32'(HEADER_BYTES) : '0;
               rsp_header_in   = done ? hit_ff.header : '0;
               rsp_size_in     = done ? hit_ff.size : '0;
               if (kind_ff == K_QUERY) begin
                  rsp_in_use_in = hit_ff.used;
               end else begin
                  rsp_in_use_in = kind_ff == K_REUSE || kind_ff == K_APPEND;
               end
               rsp_end_in      = bump_in;
               rsp_used_in     = used_total_in;
               rsp_reserved_in = reserved_in;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // region_start write empties the heap
      if (cfg.clear) begin
         count_in      = '0;
         bump_in       = cfg.start;
         reserved_in   = '0;
         used_total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chk_valid_ff  <= 1'b0;
         count_ff      <= '0;
         bump_ff       <= '0;
         reserved_ff   <= '0;
         used_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_valid_ff  <= chk_valid_in;
         count_ff      <= count_in;
         bump_ff       <= bump_in;
         reserved_ff   <= reserved_in;
         used_total_ff <= used_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      req_bytes_ff    <= req_bytes_in;
      target_ff       <= target_in;
      idx_ff          <= idx_in;
      need_ff         <= need_in;
      scan_ptr_ff     <= scan_ptr_in;
      chk_last_ff     <= chk_last_in;
      chk_idx_ff      <= chk_idx_in;
      kind_ff         <= kind_in;
      fail_status_ff  <= fail_status_in;
      hit_ff          <= hit_in;
      hit_idx_ff      <= hit_idx_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_payload_ff  <= rsp_payload_in;
      rsp_header_ff   <= rsp_header_in;
      rsp_size_ff     <= rsp_size_in;
      rsp_in_use_ff   <= rsp_in_use_in;
      rsp_end_ff      <= rsp_end_in;
      rsp_used_ff     <= rsp_used_in;
      rsp_reserved_ff <= rsp_reserved_in;
   end

   assign req_ready          = state_ff == S_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_payload = rsp_payload_ff;
   assign rsp_result_header  = rsp_header_ff;
   assign rsp_result_size    = rsp_size_ff;
   assign rsp_result_in_use  = rsp_in_use_ff;
   assign rsp_region_end     = rsp_end_ff;
   assign rsp_bytes_in_use   = rsp_used_ff;
   assign rsp_bytes_reserved = rsp_reserved_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted item did not start work");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BLOCKS))
      else $error("block count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CW'(1) || count_ff == '0))
      else $error("block count moved by more than one");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff) == S_COMMIT)
      else $error("result raised outside commit");

   a_write_in_commit: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_COMMIT && !mem_rd_en))
      else $error("table write overlaps a read");

endmodule

`default_nettype wire

/* design/first_fit_block_allocator.sv */
// First-fit block allocator.
// req_ channel: one item per handshake, op selects allocate, free or query.
// rsp_ channel: exactly one result item per accepted item, in order.
// csr_ port (APB, pready tied high): 0x0 region_start, 0x4 region_bytes.
//   Writing region_start empties the block table and resets the bump end;
//   write configuration only while no item is in flight.
// The first-fit search and the free lookup read the block table one entry per
// cycle through its single synchronous read port. One item is worked at a
// time: a new item is accepted only after the last one has left S_COMMIT.
// The result sits in an output register: the next item is accepted while
// it waits, but that item's result is held back until rsp_ready takes the
// earlier one.
// Reset empties the table, region_start = 0, region_bytes = 65536.
`default_nettype none

module first_fit_block_allocator #(
   parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_request_bytes,
   input  wire logic [31:0] req_payload_address,
   input  wire logic [5:0]  req_block_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_result_payload,
   output logic [31:0]      rsp_result_header,
   output logic [31:0]      rsp_result_size,
   output logic             rsp_result_in_use,
   output logic [31:0]      rsp_region_end,
   output logic [31:0]      rsp_bytes_in_use,
   output logic [31:0]      rsp_bytes_reserved,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import ffba_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);

   localparam logic REG_REGION_START = 1'b0;
   localparam logic REG_REGION_BYTES = 1'b1;

   logic [31:0] region_start_ff, region_start_in;
   logic [31:0] region_bytes_ff, region_bytes_in;
   logic        csr_write;
   cfg_type     cfg;

   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   entry_type     mem_wr_data;
   logic          mem_rd_en;
   logic [IW-1:0] mem_rd_addr;
   entry_type     mem_rd_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      region_start_in = region_start_ff;
      region_bytes_in = region_bytes_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_REGION_START) begin
            region_start_in = csr_pwdata;
         end else begin
            region_bytes_in = csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_bytes_ff <= 32'd65536;
      end else begin
         region_start_ff <= region_start_in;
         region_bytes_ff <= region_bytes_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_REGION_BYTES) ? region_bytes_ff : region_start_ff;

   assign cfg.clear = csr_write && (csr_paddr[2] == REG_REGION_START);
   assign cfg.start = csr_pwdata;
   assign cfg.bytes = region_bytes_ff;

   ffba_table #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ffba_ctrl #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_request_bytes   (req_request_bytes),
      .req_payload_address (req_payload_address),
      .req_block_index     (req_block_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_result_payload  (rsp_result_payload),
      .rsp_result_header   (rsp_result_header),
      .rsp_result_size     (rsp_result_size),
      .rsp_result_in_use   (rsp_result_in_use),
      .rsp_region_end      (rsp_region_end),
      .rsp_bytes_in_use    (rsp_bytes_in_use),
      .rsp_bytes_reserved  (rsp_bytes_reserved),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_en           (mem_rd_en),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_data         (mem_rd_data)
   );

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ffba_pkg::*;

   localparam int          HDR          = HEADER_BYTES_DEF;
   localparam int          NBLK         = MAX_BLOCKS_DEF;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [2:0]  ADDR_START   = 3'd0;
   localparam logic [2:0]  ADDR_BYTES   = 3'd4;
   localparam int          HOLD_CYCLES  = 500;
   localparam int          TAIL_CYCLES  = NBLK + 8;
   localparam int          CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] payload;
      logic [31:0] header;
      logic [31:0] size;
      logic        in_use;
      logic [31:0] end_addr;
      logic [31:0] used_bytes;
      logic [31:0] reserved_bytes;
   } heap_outcome_type;

   class alloc_scoreboard;
      logic [31:0]      region_base;
      logic [31:0]      region_limit;
      logic [31:0]      blk_size [NBLK];
      logic             blk_used [NBLK];
      logic [31:0]      blk_header [NBLK];
      int unsigned      blk_count;
      logic [31:0]      bump;
      logic [31:0]      used_total;
      heap_outcome_type expected_outcomes [$];
      int               errors;

      function new();
         region_base  = 32'd0;
         region_limit = 32'd65536;
         errors       = 0;
         clear_heap();
      endfunction

      function void clear_heap();
         blk_count  = 0;
         bump       = region_base;
         used_total = 32'd0;
      endfunction

      function void write_reg(logic [2:0] addr, logic [31:0] value);
         if (addr == ADDR_START) begin
            region_base = value;
            clear_heap();
         end else if (addr == ADDR_BYTES) begin
            region_limit = value;
         end
      endfunction

      function heap_outcome_type block_view(int unsigned i);
         heap_outcome_type r;
         r         = '0;
         r.status  = ST_DONE;
         r.header  = blk_header[i];
         r.payload = blk_header[i] + 32'(HDR);
         r.size    = blk_size[i];
         r.in_use  = blk_used[i];
         return r;
      endfunction

      // works out the result of one accepted item and updates the heap
      function void note_request(logic [1:0] op, logic [31:0] req_bytes,
                                 logic [31:0] addr, logic [5:0] idx);
         heap_outcome_type  r;
         int unsigned       i;
         bit                hit;
         logic [31:0]       span;
         logic [31:0]       pay;
         longint unsigned   reserved;
         longint unsigned   need;
         longint unsigned   new_end;
         r        = '0;
         r.status = ST_IGNORED;
         hit      = 1'b0;
         case (op)
            OP_ALLOC: begin
               if (req_bytes != 0) begin
                  for (i = 0; i < blk_count && !hit; i++) begin
                     if (!blk_used[i] && blk_size[i] >= req_bytes) begin
                        blk_used[i] = 1'b1;
                        used_total  = used_total + blk_size[i];
                        r   = block_view(i);
                        hit = 1'b1;
                     end
                  end
                  if (!hit) begin
                     span     = bump - region_base;
                     reserved = 64'(span);
                     need     = 64'(HDR) + 64'(req_bytes);
                     new_end  = 64'(bump) + need;
                     if (blk_count >= NBLK || reserved + need > 64'(region_limit) ||
                         new_end > 64'hFFFF_FFFF) begin
                        r.status = ST_NO_ROOM;
                     end else begin
                        blk_header[blk_count] = bump;
                        blk_size[blk_count]   = req_bytes;
                        blk_used[blk_count]   = 1'b1;
                        r          = block_view(blk_count);
                        blk_count  = blk_count + 1;
                        bump       = new_end[31:0];
                        used_total = used_total + req_bytes;
                     end
                  end
               end
            end
            OP_FREE: begin
               if (addr != 0) begin
                  for (i = 0; i < blk_count && !hit; i++) begin
                     pay = blk_header[i] + 32'(HDR);
                     if (pay == addr) begin
                        hit = 1'b1;
                        // a block that is already free is left alone
                        if (blk_used[i]) begin
                           blk_used[i] = 1'b0;
                           used_total  = used_total - blk_size[i];
                           r = block_view(i);
                        end
                     end
                  end
               end
            end
            OP_QUERY: begin
               if (32'(idx) < blk_count)
                  r = block_view(32'(idx));
               else
                  r.status = ST_NO_BLOCK;
            end
            default: ;
         endcase
         r.end_addr       = bump;
         r.used_bytes     = used_total;
         r.reserved_bytes = bump - region_base;
         expected_outcomes.push_back(r);
      endfunction

      function void check_outcome(heap_outcome_type got);
         heap_outcome_type want;
         logic [31:0]      w [8];
         logic [31:0]      g [8];
         string            tag [8];
         int               i;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: result item with nothing expected, status %0d",
                     $time, got.status);
            errors++;
            return;
         end
         want = expected_outcomes.pop_front();
         w = '{32'(want.status), want.payload, want.header, want.size, 32'(want.in_use),
               want.end_addr, want.used_bytes, want.reserved_bytes};
         g = '{32'(got.status), got.payload, got.header, got.size, 32'(got.in_use),
               got.end_addr, got.used_bytes, got.reserved_bytes};
         tag = '{"status", "result_payload", "result_header", "result_size",
                 "result_in_use", "region_end", "bytes_in_use", "bytes_reserved"};
         for (i = 0; i < 8; i++) begin
            if (w[i] !== g[i]) begin
               $display("%0t: %s mismatch, expected %h, actual %h",
                        $time, tag[i], w[i], g[i]);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_ALLOC;
   logic [31:0] req_request_bytes = 32'd0;
   logic [31:0] req_payload_address = 32'd0;
   logic [5:0]  req_block_index = 6'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_result_payload;
   logic [31:0] rsp_result_header;
   logic [31:0] rsp_result_size;
   logic        rsp_result_in_use;
   logic [31:0] rsp_region_end;
   logic [31:0] rsp_bytes_in_use;
   logic [31:0] rsp_bytes_reserved;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   alloc_scoreboard  sb = new();
   heap_outcome_type seen;
   int               gap_odds = 0;
   int               stall_odds = 0;
   bit               hold_off = 1'b0;
   int unsigned      cycles = 0;

   first_fit_block_allocator dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   assign seen = {rsp_status, rsp_result_payload, rsp_result_header, rsp_result_size,
                  rsp_result_in_use, rsp_region_end, rsp_bytes_in_use,
                  rsp_bytes_reserved};

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_outcome(seen);
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("first_fit_block_allocator test failed");
      $finish;
   end

   // write one register, then read it back
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(addr, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         $display("%0t: readback of %h mismatch, expected %h, actual %h",
                  $time, addr, value, csr_prdata);
         sb.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_item(input logic [1:0] op, input logic [31:0] nbytes,
                            input logic [31:0] addr, input logic [5:0] idx);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_request_bytes   <= nbytes;
      req_payload_address <= addr;
      req_block_index     <= idx;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, nbytes, addr, idx);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (sb.expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int n_items, input int alloc_pct, input int hold_at,
                            input bit idle);
      int          k;
      int          roll;
      int          pick;
      int unsigned j;
      logic [1:0]  op;
      logic [31:0] nbytes;
      logic [31:0] addr;
      logic [5:0]  idx;
      gap_odds   = idle ? $urandom_range(3, 12) : 0;
      stall_odds = idle ? $urandom_range(3, 12) : 0;
      for (k = 0; k < n_items; k++) begin
         if (k == hold_at)
            hold_off = 1'b1;
         roll   = $urandom_range(0, 99);
         pick   = $urandom_range(0, 19);
         j      = (sb.blk_count > 0) ? $urandom_range(0, sb.blk_count - 1) : 0;
         nbytes = $urandom;
         addr   = $urandom;
         idx    = 6'($urandom);
         if (roll < alloc_pct) begin
            op = OP_ALLOC;
            if (pick < 12)
               nbytes = $urandom_range(1, 48);
            else if (pick < 15)
               nbytes = $urandom_range(1, 600);
            else if (pick < 17 && sb.blk_count > 0)
               nbytes = sb.blk_size[j];
            else if (pick == 17)
               nbytes = 32'd0;
            else if (pick == 18)
               nbytes = $urandom >> $urandom_range(0, 31);
         end else if (roll < alloc_pct + (96 - alloc_pct) / 2) begin
            op = OP_FREE;
            if (pick < 15 && sb.blk_count > 0)
               addr = sb.blk_header[j] + 32'(HDR);
            else if (pick < 17)
               addr = 32'd0;
            else if (pick == 17 && sb.blk_count > 0)
               addr = sb.blk_header[j] + $urandom_range(0, 12);
         end else if (roll < 96) begin
            op = OP_QUERY;
            if (sb.blk_count > 0 && pick < 15)
               idx = 6'(j);
         end else begin
            op = OP_UNUSED;
         end
         send_item(op, nbytes, addr, idx);
      end
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      gap_odds   = 4;
      stall_odds = 4;

      // directed: default region, start 0 and 64 KiB
      send_item(OP_QUERY, $urandom, $urandom, 6'd0);              // empty table
      send_item(OP_FREE, $urandom, 32'd0, 6'($urandom));          // null free
      send_item(OP_FREE, $urandom, 32'd6, 6'($urandom));          // nothing allocated yet
      send_item(OP_ALLOC, 32'd0, $urandom, 6'($urandom));         // zero request
      send_item(OP_ALLOC, 32'hFFFF_FFFF, $urandom, 6'($urandom)); // past region limit
      send_item(OP_ALLOC, 32'd10, $urandom, 6'($urandom));
      send_item(OP_ALLOC, 32'd20, $urandom, 6'($urandom));
      send_item(OP_FREE, $urandom, 32'd6, 6'($urandom));
      send_item(OP_FREE, $urandom, 32'd6, 6'($urandom));          // double free
      send_item(OP_FREE, $urandom, 32'd7, 6'($urandom));          // not a payload address
      send_item(OP_ALLOC, 32'd5, $urandom, 6'($urandom));         // reuses the 10-byte block
      send_item(OP_QUERY, $urandom, $urandom, 6'd1);
      send_item(OP_QUERY, $urandom, $urandom, 6'd63);
      send_item(OP_UNUSED, $urandom, $urandom, 6'($urandom));
      send_item(OP_FREE, $urandom, 32'd22, 6'($urandom));
      send_item(OP_FREE, $urandom, 32'hFFFF_FFFF, 6'($urandom));
      // exactly fills the region
      send_item(OP_ALLOC, sb.region_limit - (sb.bump - sb.region_base) - 32'(HDR),
                $urandom, 6'($urandom));
      send_item(OP_ALLOC, 32'd21, $urandom, 6'($urandom));        // no free fit, no room
      send_item(OP_ALLOC, 32'd20, $urandom, 6'($urandom));        // exact-size reuse
      send_item(OP_QUERY, $urandom, $urandom, 6'd2);
      send_item(OP_FREE, $urandom, sb.blk_header[2] + 32'(HDR), 6'($urandom));
      drain();

      csr_write(ADDR_START, 32'h0000_1000);
      csr_write(ADDR_BYTES, 32'd300);
      run_phase(70, 45, -1, 1'b1);

      // appends run into the top of the address space
      csr_write(ADDR_BYTES, 32'hFFFF_FFFF);
      csr_write(ADDR_START, 32'hFFFF_FF00);
      run_phase(50, 50, -1, 1'b1);

      csr_write(ADDR_START, 32'hFFFF_FFFF);
      csr_write(ADDR_BYTES, 32'd0);
      run_phase(20, 50, -1, 1'b1);

      // alloc-heavy, fills the table; result side holds off for a while
      csr_write(ADDR_START, 32'h2000_0000);
      csr_write(ADDR_BYTES, 32'hFFFF_FFFF);
      run_phase(130, 85, 30, 1'b1);

      // shrinking the limit keeps the table
      csr_write(ADDR_BYTES, 32'd3000);
      run_phase(40, 40, -1, 1'b1);

      csr_write(ADDR_START, 32'd0);
      csr_write(ADDR_BYTES, 32'd65536);
      run_phase(80, 40, -1, 1'b1);
      run_phase(60, 40, -1, 1'b0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_outcomes.size() == 0)
         $display("first_fit_block_allocator test passed");
      else
         $display("first_fit_block_allocator test failed");
      $finish;
   end

endmodule

/* sim.f */
design/ffba_pkg.sv
design/ffba_table.sv
design/ffba_ctrl.sv
design/first_fit_block_allocator.sv
sim/tb.sv
